/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLY(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

/* hdl/rfa_pkg.sv */
// ----------------------------------------------------------------------------
// rfa_pkg
// types and codes shared by the frame allocator files
// ----------------------------------------------------------------------------
package rfa_pkg;
  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_REF   = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_MUSED = 3'd4;
  localparam logic [2:0] OP_MFREE = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OOM     = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_DOUBLE  = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_MOD, S_SCAN, S_RANGE, S_OUT
  } state_t;
endpackage

/* hdl/refcounted_frame_allocator.sv */
// ----------------------------------------------------------------------------
// refcounted_frame_allocator
// bitmap frame allocator with 16-bit reference counts per frame
// ----------------------------------------------------------------------------
// One frame entry (used bit and count) lives in a single-port synchronous
// memory. After reset a clearing pass writes every entry as used with count
// zero, during which no request is accepted. Reference, free and query step
// through read, modify and write back, result and idle; an invalid frame or
// an unknown operation goes straight to the result. Allocate reads one entry
// at a time from frame 0 until it finds the first free frame or runs out of
// frames. A range mark reads and writes back each frame in turn, and an empty
// range goes straight to the result. One request is in work at a time. A
// finished result waits in the last state until the output register is free,
// so a new request is taken while an earlier result is still held by a stall
// on the output.
module refcounted_frame_allocator
  import rfa_pkg::*;
#(
  parameter int MAX_FRAME_COUNT = 32768,
  parameter int FRAME_BYTES     = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] frame,
  input  logic [31:0] base_address,
  input  logic [31:0] region_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] allocated_frame,
  output logic [15:0] count_value,
  output logic [2:0]  status,
  output logic        memory_exhausted
);
  localparam int AW = $clog2(MAX_FRAME_COUNT);
  localparam int CW = AW + 1;
  localparam int SH = $clog2(FRAME_BYTES);

  logic [16:0] mem [MAX_FRAME_COUNT];
  logic [16:0] rd;
  logic        we;
  logic [AW-1:0] addr;
  logic [16:0] wd;

  state_t state, state_next;
  logic [15:0] frames_in_use;
  logic [CW-1:0] lim, idx, idx_next, rend, rend_next;
  logic [2:0] op;
  logic [2:0] st, st_next;
  logic [15:0] cnt, cnt_next;
  logic [14:0] got, got_next;
  logic flag, flag_next;
  logic busy;
  logic out_load;

  logic [16:0] lim_w;
  logic [32:0] endsum;
  logic [32:0] endfr;
  logic [32:0] startfr;
  logic        fok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    rd <= mem[addr];
  end

  assign lim_w = (frames_in_use > 16'(MAX_FRAME_COUNT > 65535 ? 65535 : MAX_FRAME_COUNT))
                 ? 17'(MAX_FRAME_COUNT) : {1'b0, frames_in_use};
  assign lim = CW'(lim_w);
  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);
  assign endsum = {1'b0, base_address} + {1'b0, region_length} + 33'(FRAME_BYTES - 1);
  assign endfr = endsum >> SH;
  assign startfr = {1'b0, base_address} >> SH;
  assign fok = (frame != 32'd0) && (frame < {15'd0, lim_w});

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 16'd32768;
    end else if (cfg_valid) begin
      frames_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      flag <= flag_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rend <= rend_next;
    st <= st_next;
    cnt <= cnt_next;
    got <= got_next;
    if (state == S_IDLE && in_valid) begin
      op <= operation;
    end
    if (out_load) begin
      allocated_frame <= got;
      count_value <= cnt;
      status <= st;
      memory_exhausted <= flag;
    end
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    rend_next = rend;
    st_next = st;
    cnt_next = cnt;
    got_next = got;
    flag_next = flag;
    we = 1'b0;
    addr = idx[AW-1:0];
    wd = '0;
    busy = 1'b0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wd = {1'b1, 16'd0};
        idx_next = idx + 1'b1;
        if (idx == CW'(MAX_FRAME_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          st_next = ST_OK;
          cnt_next = '0;
          got_next = '0;
          idx_next = '0;
          addr = frame[AW-1:0];
          case (operation)
            OP_ALLOC: begin
              addr = '0;
              state_next = (lim == '0) ? S_SCAN : S_READ;
            end
            OP_REF, OP_FREE, OP_QUERY: begin
              idx_next = CW'(frame);
              if (fok) begin
                state_next = S_READ;
              end else begin
                st_next = ST_INVALID;
                state_next = S_OUT;
              end
            end
            OP_MUSED, OP_MFREE: begin
              if (endfr > {16'd0, lim_w}) begin
                rend_next = lim;
                st_next = ST_TRUNC;
              end else begin
                rend_next = CW'(endfr);
              end
              if (startfr >= (endfr > {16'd0, lim_w} ? {16'd0, lim_w} : endfr)) begin
                state_next = S_OUT;
              end else begin
                idx_next = CW'(startfr);
                addr = startfr[AW-1:0];
                state_next = S_READ;
              end
            end
            default: state_next = S_OUT;
          endcase
        end
      end
      S_READ: begin
        busy = 1'b1;
        state_next = (op == OP_ALLOC) ? S_SCAN : (op >= OP_MUSED) ? S_RANGE : S_MOD;
      end
      S_MOD: begin
        case (op)
          OP_REF: begin
            we = 1'b1;
            wd = {rd[16], rd[15:0] + 16'd1};
          end
          OP_FREE: begin
            if (rd[15:0] == 16'd0) begin
              st_next = ST_DOUBLE;
            end else begin
              we = 1'b1;
              wd = {rd[16] && (rd[15:0] != 16'd1), rd[15:0] - 16'd1};
            end
          end
          default: cnt_next = rd[15:0];
        endcase
        state_next = S_OUT;
      end
      S_SCAN: begin
        if (idx >= lim) begin
          flag_next = 1'b1;
          st_next = ST_OOM;
          state_next = S_OUT;
        end else if (!rd[16]) begin
          we = 1'b1;
          wd = {1'b1, 16'd1};
          flag_next = 1'b0;
          got_next = 15'(idx);
          state_next = S_OUT;
        end else begin
          idx_next = idx + 1'b1;
          addr = idx_next[AW-1:0];
          state_next = S_READ;
        end
      end
      S_RANGE: begin
        we = 1'b1;
        if (op == OP_MUSED) begin
          wd = {1'b1, (rd[15:0] == 16'd0) ? 16'd1 : rd[15:0]};
        end else begin
          wd = '0;
        end
        idx_next = idx + 1'b1;
        if (idx_next >= rend) begin
          state_next = S_OUT;
        end else begin
          state_next = S_READ;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_READ && op != OP_ALLOC) begin
      addr = idx[AW-1:0];
    end
    if (state == S_RANGE && state_next == S_READ) begin
      // read of next entry is issued from S_READ using idx
      addr = idx[AW-1:0];
    end
    if (busy && op == OP_ALLOC) begin
      addr = idx[AW-1:0];
    end
  end
endmodule

/* hdl/rfa_checker.sv */
// ----------------------------------------------------------------------------
// rfa_checker
// port-level checks on the frame allocator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rfa_checker
  import rfa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [14:0] allocated_frame,
  input logic [15:0] count_value,
  input logic [2:0]  status
);
  `CHK_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status))
  `CHK_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid)
  `CHK_IMPLY(a_oom, clk, rst, out_valid && status == ST_OOM, allocated_frame == 15'd0)
  `CHK_IMPLY(a_inv, clk, rst, out_valid && status == ST_INVALID, count_value == 16'd0)
  `CHK_IMPLY(a_code, clk, rst, out_valid, status <= ST_TRUNC)
endmodule

bind refcounted_frame_allocator rfa_checker u_rfa_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .allocated_frame(allocated_frame),
  .count_value(count_value), .status(status)
);
